[rtl/core/dip_pkg.sv]
// Package for the decimal id array parser.
// Holds element types, phase codes, character constants and the null-literal table.
// No dependencies; read before the interfaces and the top level.
package dip_pkg;

    // Element type codes written through the configuration channel.
    typedef enum logic [1:0] {
        ET_S32 = 2'd0,
        ET_S64 = 2'd1,
        ET_U32 = 2'd2,
        ET_U64 = 2'd3
    } elem_type_t;

    // Progress through the current element.
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_MINUS  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Byte position saturates here; the null literal is this long.
    localparam logic [2:0] POS_SAT  = 3'd6;
    localparam logic [2:0] POS_LAST = 3'd5;

    // Characters of the literal {NULL}, indexed by byte position.
    function automatic logic [7:0] null_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h7B;
            3'd1:    ch = 8'h4E;
            3'd2:    ch = 8'h55;
            3'd3:    ch = 8'h4C;
            3'd4:    ch = 8'h4C;
            3'd5:    ch = 8'h7D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/dip_if.sv]
// Channel interfaces of the decimal id array parser: text bytes in, results out,
// and the configuration write channel. Depends on dip_pkg.
interface dip_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_end;

    modport source (output valid, output text_byte, output string_end, input ready);
    modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface dip_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] id_bits;
    logic        has_id;
    logic        conversion_error;
    logic        end_of_array;

    modport source (output valid, output id_bits, output has_id,
                    output conversion_error, output end_of_array, input ready);
    modport sink   (input valid, input id_bits, input has_id,
                    input conversion_error, input end_of_array, output ready);
endinterface

interface dip_cfg_if;
    import dip_pkg::*;
    logic       valid;
    logic       ready;
    elem_type_t element_type;

    modport source (output valid, output element_type, input ready);
    modport sink   (input valid, input element_type, output ready);
endinterface

[rtl/core/decimal_id_array_parser_top.sv]
// Top level of the decimal id array parser.
// Depends on dip_pkg and the channel interfaces in dip_if.sv.
//
// Usage: the text channel carries one character item per cycle; string_end
// marks the last byte of a brace-delimited array such as {1,-2,3}. Byte 0 is
// never part of an element; each later comma or close brace ends an element,
// but not the close brace of {NULL}. The result channel carries one item per
// ended element (value or error) or final byte, with end_of_array set for the
// final byte. After the first error of a string no further element items appear
// until the final byte. The configuration channel writes element_type; it is
// always ready and must only be written while no text item is offered and no
// result is pending. A change inside a string applies from the next byte on.
// Latency: a result is visible in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; the per-byte state
// update (multiply by ten and add, range check) is combinational, and a single
// result register separates the two sides.
// When the receiver stalls, the result register holds and the text channel
// drops ready until the result is taken or that same cycle frees the register.
// Reset clears all parse state and sets element_type to signed 64-bit.
module decimal_id_array_parser_top
    import dip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dip_text_if.sink          text_in,
    dip_result_if.source      result_out,
    dip_cfg_if.sink           cfg
);

    // Configuration and parse state.
    elem_type_t  elem_type_reg;
    logic [2:0]  byte_pos_reg, byte_pos_next;
    logic        null_match_reg, null_match_next;
    phase_t      phase_reg, phase_next;
    logic [63:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        range_reg, range_next;
    logic        err_seen_reg, err_seen_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [63:0] id_bits_reg, id_bits_next;
    logic        has_id_reg, has_id_next;
    logic        conv_err_reg, conv_err_next;
    logic        end_reg, end_next;

    logic        accept;
    logic        last;
    logic [7:0]  ch;
    logic        is_digit;
    logic        is_delim;
    logic        active;
    logic        is_null;
    logic        end_elem;
    logic        emit;
    logic        signed_type;
    logic        null_char_ok;
    logic [67:0] acc_wide;
    logic        fin_err;
    logic        over_limit;
    logic [63:0] fin_value;

    assign cfg.ready     = 1'b1;
    assign text_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = text_in.valid && text_in.ready;
    assign last          = text_in.string_end;
    assign ch            = text_in.text_byte;

    // Character classes and element boundary decode.
    assign is_digit     = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_delim     = (ch == CHAR_COMMA) || (ch == CHAR_CLOSE);
    assign signed_type  = (elem_type_reg == ET_S32) || (elem_type_reg == ET_S64);
    assign null_char_ok = (byte_pos_reg != POS_SAT) && (ch == null_char(byte_pos_reg));
    assign active       = (byte_pos_reg != 3'd0) && !err_seen_reg;
    assign is_null      = null_match_reg && null_char_ok && (byte_pos_reg == POS_LAST) && last;
    assign end_elem     = active && is_delim && !is_null;
    assign emit         = end_elem || last;

    // Decimal accumulate: ten times the magnitude plus the new digit, with carry-out.
    assign acc_wide = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                    + {64'b0, ch[3:0]};

    // Range check of the element that ends on this byte.
    always_comb
    begin
        unique case (elem_type_reg)
            ET_S32:  over_limit = neg_reg ? (mag_reg > 64'h0000_0000_8000_0000)
                                          : (mag_reg > 64'h0000_0000_7FFF_FFFF);
            ET_S64:  over_limit = neg_reg ? (mag_reg > 64'h8000_0000_0000_0000)
                                          : mag_reg[63];
            ET_U32:  over_limit = neg_reg || (mag_reg[63:32] != 32'd0);
            ET_U64:  over_limit = neg_reg;
            default: over_limit = 1'b1;
        endcase
    end

    assign fin_err   = (phase_reg == PH_START) || (phase_reg == PH_MINUS)
                     || range_reg || over_limit;
    assign fin_value = neg_reg ? (64'd0 - mag_reg) : mag_reg;

    // Next parse state for an accepted byte.
    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        null_match_next = null_match_reg;
        phase_next      = phase_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        range_next      = range_reg;
        err_seen_next   = err_seen_reg;

        if (accept) begin
            if (last) begin
                byte_pos_next   = 3'd0;
                null_match_next = 1'b1;
                err_seen_next   = 1'b0;
                phase_next      = PH_START;
                mag_next        = 64'd0;
                neg_next        = 1'b0;
                range_next      = 1'b0;
            end else begin
                if (byte_pos_reg != POS_SAT) begin
                    byte_pos_next = byte_pos_reg + 3'd1;
                end
                null_match_next = null_match_reg && null_char_ok;
                if (end_elem && fin_err) begin
                    err_seen_next = 1'b1;
                end
                if (active && is_delim) begin
                    phase_next = PH_START;
                    mag_next   = 64'd0;
                    neg_next   = 1'b0;
                    range_next = 1'b0;
                end else if (active) begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            if (is_digit) begin
                                mag_next   = {60'd0, ch[3:0]};
                                phase_next = PH_DIGITS;
                            end else if (ch == CHAR_MINUS && signed_type) begin
                                neg_next   = 1'b1;
                                phase_next = PH_MINUS;
                            end else begin
                                range_next = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_MINUS:
                        begin
                            if (is_digit) begin
                                mag_next   = {60'd0, ch[3:0]};
                                phase_next = PH_DIGITS;
                            end else begin
                                range_next = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (!is_digit) begin
                                phase_next = PH_SKIP;
                            end else if (!range_reg) begin
                                if (acc_wide[67:64] != 4'd0) begin
                                    range_next = 1'b1;
                                end else begin
                                    mag_next = acc_wide[63:0];
                                end
                            end
                        end
                        PH_SKIP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Next result register contents.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_out.ready;
        id_bits_next   = id_bits_reg;
        has_id_next    = has_id_reg;
        conv_err_next  = conv_err_reg;
        end_next       = end_reg;
        if (accept && emit) begin
            out_valid_next = 1'b1;
            has_id_next    = end_elem && !fin_err;
            conv_err_next  = end_elem && fin_err;
            id_bits_next   = (end_elem && !fin_err) ? fin_value : 64'd0;
            end_next       = last;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            elem_type_reg  <= ET_S64;
            byte_pos_reg   <= 3'd0;
            null_match_reg <= 1'b1;
            phase_reg      <= PH_START;
            mag_reg        <= 64'd0;
            neg_reg        <= 1'b0;
            range_reg      <= 1'b0;
            err_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg.valid) begin
                elem_type_reg <= cfg.element_type;
            end
            byte_pos_reg   <= byte_pos_next;
            null_match_reg <= null_match_next;
            phase_reg      <= phase_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            range_reg      <= range_next;
            err_seen_reg   <= err_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        id_bits_reg  <= id_bits_next;
        has_id_reg   <= has_id_next;
        conv_err_reg <= conv_err_next;
        end_reg      <= end_next;
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.id_bits          = id_bits_reg;
    assign result_out.has_id           = has_id_reg;
    assign result_out.conversion_error = conv_err_reg;
    assign result_out.end_of_array     = end_reg;

endmodule

[tb/tb_decimal_id_array_parser_top.sv]
// Self-checking testbench for decimal_id_array_parser_top: a short directed table,
// then random array text, checked item by item against an in-bench parser model.
// Depends on dip_pkg and the channel interfaces in dip_if.sv.
module tb_decimal_id_array_parser_top
    import dip_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 1250;
    localparam int CALM_FROM      = 1050;
    localparam int HOLD_FROM      = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_LIMIT    = 5000;
    localparam logic [47:0] NULL_LIT = "{NULL}";

    // Result as it leaves the block.
    typedef struct packed {
        logic [63:0] id_bits;
        logic        has_id;
        logic        conversion_error;
        logic        end_of_array;
    } id_result_t;

    // A result typed into the table travels with its text item.
    typedef struct packed {
        logic       given;
        id_result_t want;
    } byte_tag_t;

    typedef enum logic [1:0] {
        ROW_PRED  = 2'd0,
        ROW_GIVEN = 2'd1,
        ROW_CFG   = 2'd2
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  ch;
        logic        last;
        elem_type_t  etype;
        logic [63:0] id_bits;
        logic        has_id;
        logic        conversion_error;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dip_text_if   text_ch ();
    dip_result_if res_ch ();
    dip_cfg_if    cfg_ch ();

    decimal_id_array_parser_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    // Directed text: null literal, skipped byte 0, byte extremes, bad starts,
    // minus under an unsigned type, and a type change inside an element.
    dir_row_t dir_rows [28] = '{
        '{ROW_PRED,  "{",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "N",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "U",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "L",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "L",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, "}",   1'b1, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  ",",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "-",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "7",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, ",",   1'b0, ET_S64, 64'hFFFF_FFFF_FFFF_FFF9, 1'b1, 1'b0},
        '{ROW_PRED,  8'hFF, 1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, 8'h00, 1'b1, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "}",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "+",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, ",",   1'b0, ET_S64, 64'd0, 1'b0, 1'b1},
        '{ROW_PRED,  "2",   1'b0, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, "}",   1'b1, ET_S64, 64'd0, 1'b0, 1'b0},
        '{ROW_CFG,   8'h00, 1'b0, ET_U32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "{",   1'b0, ET_U32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "-",   1'b0, ET_U32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "1",   1'b0, ET_U32, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, "}",   1'b1, ET_U32, 64'd0, 1'b0, 1'b1},
        '{ROW_CFG,   8'h00, 1'b0, ET_S32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "{",   1'b0, ET_S32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "-",   1'b0, ET_S32, 64'd0, 1'b0, 1'b0},
        '{ROW_PRED,  "5",   1'b0, ET_S32, 64'd0, 1'b0, 1'b0},
        '{ROW_CFG,   8'h00, 1'b0, ET_U64, 64'd0, 1'b0, 1'b0},
        '{ROW_GIVEN, "}",   1'b1, ET_U64, 64'd0, 1'b0, 1'b1}
    };

    // Decimal texts around the 32-bit and 64-bit limits, and past them.
    string edge_values [13] = '{
        "0", "1", "2147483647", "2147483648", "2147483649", "4294967295",
        "4294967296", "9223372036854775807", "9223372036854775808",
        "9223372036854775809", "18446744073709551615", "18446744073709551616",
        "99999999999999999999"
    };

    byte_tag_t   offered_bytes [$];
    id_result_t  expected_ids [$];
    logic [7:0]  array_text [$];
    int          mismatch_count = 0;
    int          random_bytes = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    bit          hold_pending = 1'b0;
    bit          hold_done = 1'b0;

    // Parser state kept alongside the block.
    elem_type_t  id_type = ET_S64;
    logic [2:0]  at_pos = 3'd0;
    logic        lit_match = 1'b1;
    phase_t      elem_phase = PH_START;
    logic [63:0] accum = 64'd0;
    logic        minus_taken = 1'b0;
    logic        elem_bad = 1'b0;
    logic        string_failed = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Clears the element being parsed.
    function automatic void clear_element();
        elem_phase  = PH_START;
        accum       = 64'd0;
        minus_taken = 1'b0;
        elem_bad    = 1'b0;
    endfunction

    // Advances the parser by one text byte; returns 1 when the byte yields a result.
    function automatic logic parse_text_byte(input logic [7:0] ch, input logic last,
                                             output id_result_t res);
        logic [2:0]  pos;
        logic        emit;
        logic        is_digit;
        logic        signed_type;
        logic        failed;
        logic [63:0] dig;
        logic [63:0] lim;

        pos         = at_pos;
        emit        = 1'b0;
        res         = '0;
        is_digit    = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        dig         = {60'd0, ch[3:0]};
        signed_type = (id_type == ET_S32) || (id_type == ET_S64);

        // Track whether the string so far spells the null literal.
        if (pos < POS_SAT)
        begin
            if (ch != NULL_LIT[47 - 8 * pos -: 8])
                lit_match = 1'b0;
        end
        else
            lit_match = 1'b0;

        if (pos != 3'd0 && !string_failed)
        begin
            if (ch == CHAR_COMMA || ch == CHAR_CLOSE)
            begin
                // Element ends, unless this is the closing brace of the null literal.
                if (!(lit_match && pos == POS_LAST && last))
                begin
                    emit = 1'b1;
                    case (id_type)
                        ET_S32:  lim = minus_taken ? 64'h8000_0000 : 64'h7FFF_FFFF;
                        ET_S64:  lim = minus_taken ? 64'h8000_0000_0000_0000
                                                   : 64'h7FFF_FFFF_FFFF_FFFF;
                        ET_U32:  lim = minus_taken ? 64'd0 : 64'hFFFF_FFFF;
                        default: lim = minus_taken ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF;
                    endcase
                    failed = (elem_phase == PH_START) || (elem_phase == PH_MINUS)
                             || elem_bad || (minus_taken && !signed_type) || (accum > lim);
                    if (failed)
                    begin
                        res.conversion_error = 1'b1;
                        string_failed        = 1'b1;
                    end
                    else
                    begin
                        res.has_id  = 1'b1;
                        res.id_bits = minus_taken ? (64'd0 - accum) : accum;
                    end
                end
                clear_element();
            end
            else
            begin
                // Prefix parse: optional minus, digits, then anything.
                case (elem_phase)
                    PH_START, PH_MINUS:
                    begin
                        if (is_digit)
                        begin
                            accum      = dig;
                            elem_phase = PH_DIGITS;
                        end
                        else if (elem_phase == PH_START && ch == CHAR_MINUS && signed_type)
                        begin
                            minus_taken = 1'b1;
                            elem_phase  = PH_MINUS;
                        end
                        else
                        begin
                            elem_bad   = 1'b1;
                            elem_phase = PH_SKIP;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (!is_digit)
                            elem_phase = PH_SKIP;
                        else if (!elem_bad)
                        begin
                            if (accum > (64'hFFFF_FFFF_FFFF_FFFF - dig) / 64'd10)
                                elem_bad = 1'b1;
                            else
                                accum = accum * 64'd10 + dig;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // The final byte always gives a result and rearms the parser.
        if (last)
        begin
            emit              = 1'b1;
            res.end_of_array  = 1'b1;
            at_pos            = 3'd0;
            lit_match         = 1'b1;
            string_failed     = 1'b0;
            clear_element();
        end
        else if (pos < POS_SAT)
            at_pos = pos + 3'd1;
        return emit;
    endfunction

    // Follows both channels: predicts on each text item, checks each result item.
    always @(posedge clk)
    begin : track_ids
        id_result_t got;
        id_result_t want;
        byte_tag_t  tag;
        logic       emits;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                id_type = cfg_ch.element_type;
            if (text_ch.valid && text_ch.ready)
            begin
                tag   = offered_bytes.pop_front();
                emits = parse_text_byte(text_ch.text_byte, text_ch.string_end, want);
                if (tag.given)
                    expected_ids.push_back(tag.want);
                else if (emits)
                    expected_ids.push_back(want);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.id_bits          = res_ch.id_bits;
                got.has_id           = res_ch.has_id;
                got.conversion_error = res_ch.conversion_error;
                got.end_of_array     = res_ch.end_of_array;
                if (expected_ids.size() == 0)
                    report_mismatch($sformatf("result %h/%b%b%b with none expected",
                        got.id_bits, got.has_id, got.conversion_error, got.end_of_array));
                else
                begin
                    want = expected_ids.pop_front();
                    if (got.id_bits !== want.id_bits)
                        report_mismatch($sformatf("id_bits %h, expected %h",
                                                  got.id_bits, want.id_bits));
                    if (got.has_id !== want.has_id)
                        report_mismatch($sformatf("has_id %b, expected %b",
                                                  got.has_id, want.has_id));
                    if (got.conversion_error !== want.conversion_error)
                        report_mismatch($sformatf("conversion_error %b, expected %b",
                                                  got.conversion_error, want.conversion_error));
                    if (got.end_of_array !== want.end_of_array)
                        report_mismatch($sformatf("end_of_array %b, expected %b",
                                                  got.end_of_array, want.end_of_array));
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off counted here.
    initial
    begin
        int held;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                res_ch.ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Offers one text item, after an optional gap, and waits until it is taken.
    task automatic offer_byte(input logic [7:0] ch, input logic last,
                              input logic given, input id_result_t want);
        byte_tag_t tag;
        tag.given = given;
        tag.want  = want;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= ch;
        text_ch.string_end <= last;
        offered_bytes.push_back(tag);
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
    endtask

    // Waits until every offered item is taken and every result has come back.
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        while (offered_bytes.size() != 0 || expected_ids.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_type(input elem_type_t etype);
        wait_drained();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.element_type <= etype;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            array_text.push_back(s[i]);
    endfunction

    // One element: mostly a number, sometimes with sign, zeros, overflow or tail.
    function automatic void add_element();
        logic [63:0] v;
        logic [7:0]  junk;
        if ($urandom_range(0, 99) < 8)
        begin
            // Malformed start: empty, space, plus sign or a letter.
            case ($urandom_range(0, 3))
                0: ;
                1: push_text(" ");
                2: push_text("+");
                default: array_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
            endcase
            if ($urandom_range(0, 1) == 1)
                push_text($sformatf("%0d", $urandom_range(0, 999)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                push_text("-");
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) push_text("0");
            if ($urandom_range(0, 99) < 35)
                push_text(edge_values[$urandom_range(0, 12)]);
            else
            begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                push_text($sformatf("%0d", v));
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    push_text($sformatf("%0d", $urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0)
            begin
                junk = 8'($urandom_range(0, 255));
                if (junk == CHAR_COMMA || junk == CHAR_CLOSE)
                    junk = "x";
                array_text.push_back(junk);
                if ($urandom_range(0, 1) == 1)
                    push_text("12");
            end
        end
    endfunction

    // Builds one array text: mostly well formed, some null forms and noise.
    function automatic void build_random_array();
        int kind;
        int n_elems;
        array_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 6)
            push_text("{NULL}");
        else if (kind < 10)
        begin
            case ($urandom_range(0, 2))
                0: push_text("{NULL},5}");
                1:
                begin
                    push_text("{NUL");
                    array_text.push_back(8'($urandom_range(0, 255)));
                    push_text("}");
                end
                default: push_text("[NULL}");
            endcase
        end
        else if (kind < 18)
        begin
            repeat ($urandom_range(1, 12))
                array_text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                array_text.push_back(8'($urandom_range(0, 255)));
            else
                push_text("{");
            n_elems = $urandom_range(0, 5);
            if (n_elems == 0)
                push_text("}");
            for (int j = 0; j < n_elems; j++)
            begin
                add_element();
                push_text((j == n_elems - 1) ? "}" : ",");
            end
        end
    endfunction

    // Main sequence: reset, directed table, random arrays, drain and verdict.
    initial
    begin
        id_result_t want;
        int         spins;
        rst_n               <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.string_end  <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.element_type <= ET_S64;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_type(dir_rows[i].etype);
            else
            begin
                want.id_bits          = dir_rows[i].id_bits;
                want.has_id           = dir_rows[i].has_id;
                want.conversion_error = dir_rows[i].conversion_error;
                want.end_of_array     = dir_rows[i].last;
                offer_byte(dir_rows[i].ch, dir_rows[i].last,
                           dir_rows[i].kind == ROW_GIVEN, want);
            end
        end

        // Random arrays, with type changes between them.
        while (random_bytes < RANDOM_BYTES)
        begin
            if (random_bytes >= CALM_FROM)
            begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            else
            begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (!hold_done && random_bytes >= HOLD_FROM)
            begin
                hold_done    = 1'b1;
                hold_pending = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                write_type(elem_type_t'($urandom_range(0, 3)));
            build_random_array();
            foreach (array_text[i])
                offer_byte(array_text[i], i == array_text.size() - 1, 1'b0, '0);
            random_bytes += array_text.size();
        end

        // Drain and give the verdict.
        text_ch.valid <= 1'b0;
        spins = 0;
        while ((offered_bytes.size() != 0 || expected_ids.size() != 0)
               && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (10) @(posedge clk);
        if (offered_bytes.size() != 0 || expected_ids.size() != 0)
            report_mismatch($sformatf("%0d results never delivered", expected_ids.size()));
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
